// File: src/a2bc_pkg.sv
// Shared types and lane/address helpers for the Argon2 block compression core.
`timescale 1ns / 1ps

package a2bc_pkg;

    localparam int WORDS      = 128;
    localparam int ADDR_W     = 7;
    localparam int WORD_W     = 64;
    localparam int HALF_W     = 32;
    localparam int PAIR_LAST  = 63;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        S_LOAD     = 9'b000000001,
        S_RDA      = 9'b000000010,
        S_RDC      = 9'b000000100,
        S_LATC     = 9'b000001000,
        S_MUL      = 9'b000010000,
        S_ADD      = 9'b000100000,
        S_WR       = 9'b001000000,
        S_EMIT_RD  = 9'b010000000,
        S_EMIT_OUT = 9'b100000000
    } state_t;

    // Lane number (0..15) of slot s (a,b,c,d) in mix m: column mixes then diagonals
    function automatic logic [3:0] lane_of(input logic [2:0] m, input logic [1:0] s);
        logic [1:0] low;
        begin
            low = m[2] ? (m[1:0] + s) : m[1:0];
            lane_of = {s, low};
        end
    endfunction

    // Block word address of a lane within permutation p (rows 0..7, columns 8..15)
    function automatic logic [ADDR_W-1:0] word_addr(input logic [3:0] p,
                                                    input logic [3:0] lane);
        begin
            if (!p[3])
                word_addr = {p[2:0], lane};
            else
                word_addr = {lane[3:1], p[2:0], lane[0]};
        end
    endfunction

endpackage

// File: src/argon2_block_compress_core.sv
// Argon2 compression G (BlaMka) over one 1 KiB block with a shared mix unit.
`timescale 1ns / 1ps

// Loads 128 requests (one word each of ref, prev and old output block), then
// runs the 16 BlaMka permutations (8 rows, 8 columns) as 128 quarter mixes
// on one shared 32x32 multiply / 64-bit add unit, then sends 64 result pairs,
// tlast on the final pair. Each mix fetches its four words over two read
// ports, runs four multiply/add steps and writes them back through the
// single write port of the Z memory. Each result pair is read from the
// memories and then held until taken. No input is taken while computing
// or sending. cfg_we/cfg_wdata set the xor-into-old-block mode; no
// clearing pass is needed after reset.
module argon2_block_compress_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,          // xor_into_output
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,       // ref_word, prev_word, old_word
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,       // out_word_even, out_word_odd
    output logic         m_axis_tlast        // last_pair
);

    localparam int AW = a2bc_pkg::ADDR_W;
    localparam int DW = a2bc_pkg::WORD_W;
    localparam int HW = a2bc_pkg::HALF_W;

    a2bc_pkg::state_t state_reg, state_next;

    logic          xor_mode_reg;
    logic [AW-1:0] load_cnt_reg;
    logic [3:0]    perm_reg;
    logic [2:0]    mix_reg;
    logic [1:0]    step_reg;
    logic [1:0]    wr_cnt_reg;
    logic [5:0]    pair_reg;

    logic [DW-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [DW-1:0] prod_reg;

    logic [DW-1:0] out_even, out_odd;
    logic          out_valid_reg, out_last_reg;

    // Memories
    logic [DW-1:0] work_mem [a2bc_pkg::WORDS];
    logic [DW-1:0] feed_mem [a2bc_pkg::WORDS];
    logic [DW-1:0] z_mem    [a2bc_pkg::WORDS];
    logic [DW-1:0] work_rd0, work_rd1, feed_rd0, feed_rd1, z_rd0, z_rd1;

    logic          in_acc, out_acc;
    logic [AW-1:0] rd_addr0, rd_addr1, z_wr_addr;
    logic [DW-1:0] z_wr_data;
    logic          z_we;
    logic [DW-1:0] op_x, op_y, op_o, sum, mixed, wb_data;
    logic          last_mix, last_perm;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign out_acc = out_valid_reg && m_axis_tready;
    assign s_axis_tready = (state_reg == a2bc_pkg::S_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {out_odd, out_even};
    assign m_axis_tlast = out_last_reg;
    assign last_mix = (mix_reg == 3'd7);
    assign last_perm = (perm_reg == 4'd15);

    // Read address selection
    always_comb
    begin
        rd_addr0 = {pair_reg, 1'b0};
        rd_addr1 = {pair_reg, 1'b1};
        if (state_reg == a2bc_pkg::S_RDA)
        begin
            rd_addr0 = a2bc_pkg::word_addr(perm_reg, a2bc_pkg::lane_of(mix_reg, 2'd0));
            rd_addr1 = a2bc_pkg::word_addr(perm_reg, a2bc_pkg::lane_of(mix_reg, 2'd1));
        end
        else if (state_reg == a2bc_pkg::S_RDC)
        begin
            rd_addr0 = a2bc_pkg::word_addr(perm_reg, a2bc_pkg::lane_of(mix_reg, 2'd2));
            rd_addr1 = a2bc_pkg::word_addr(perm_reg, a2bc_pkg::lane_of(mix_reg, 2'd3));
        end
    end

    // Write-back data of the current mix
    always_comb
    begin
        unique case (wr_cnt_reg)
            2'd0: wb_data = a_reg;
            2'd1: wb_data = b_reg;
            2'd2: wb_data = c_reg;
            default: wb_data = d_reg;
        endcase
    end

    // Z memory write port: loading or mix write-back
    always_comb
    begin
        z_we = in_acc || (state_reg == a2bc_pkg::S_WR);
        if (state_reg == a2bc_pkg::S_WR)
        begin
            z_wr_addr = a2bc_pkg::word_addr(perm_reg, a2bc_pkg::lane_of(mix_reg, wr_cnt_reg));
            z_wr_data = wb_data;
        end
        else
        begin
            z_wr_addr = load_cnt_reg;
            z_wr_data = s_axis_tdata[63:0] ^ s_axis_tdata[127:64];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            work_mem[load_cnt_reg] <= s_axis_tdata[63:0] ^ s_axis_tdata[127:64];
            feed_mem[load_cnt_reg] <= s_axis_tdata[191:128];
        end
        if (z_we)
            z_mem[z_wr_addr] <= z_wr_data;
        work_rd0 <= work_mem[rd_addr0];
        work_rd1 <= work_mem[rd_addr1];
        feed_rd0 <= feed_mem[rd_addr0];
        feed_rd1 <= feed_mem[rd_addr1];
        z_rd0    <= z_mem[rd_addr0];
        z_rd1    <= z_mem[rd_addr1];
    end

    // Shared BlaMka unit: even steps a+=b, odd steps c+=d
    assign op_x = step_reg[0] ? c_reg : a_reg;
    assign op_y = step_reg[0] ? d_reg : b_reg;
    assign op_o = step_reg[0] ? b_reg : d_reg;
    assign sum  = op_x + op_y + {prod_reg[DW-2:0], 1'b0};

    always_comb
    begin
        logic [DW-1:0] t;
        t = op_o ^ sum;
        unique case (step_reg)
            2'd0: mixed = {t[31:0], t[63:32]};
            2'd1: mixed = {t[23:0], t[63:24]};
            2'd2: mixed = {t[15:0], t[63:16]};
            default: mixed = {t[62:0], t[63]};
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            a2bc_pkg::S_LOAD:
                if (in_acc && (load_cnt_reg == AW'(a2bc_pkg::WORDS - 1)))
                    state_next = a2bc_pkg::S_RDA;
            a2bc_pkg::S_RDA:  state_next = a2bc_pkg::S_RDC;
            a2bc_pkg::S_RDC:  state_next = a2bc_pkg::S_LATC;
            a2bc_pkg::S_LATC: state_next = a2bc_pkg::S_MUL;
            a2bc_pkg::S_MUL:  state_next = a2bc_pkg::S_ADD;
            a2bc_pkg::S_ADD:
                state_next = (step_reg == 2'd3) ? a2bc_pkg::S_WR : a2bc_pkg::S_MUL;
            a2bc_pkg::S_WR:
                if (wr_cnt_reg == 2'd3)
                    state_next = (last_mix && last_perm) ? a2bc_pkg::S_EMIT_RD
                                                         : a2bc_pkg::S_RDA;
            a2bc_pkg::S_EMIT_RD: state_next = a2bc_pkg::S_EMIT_OUT;
            a2bc_pkg::S_EMIT_OUT:
                if (out_acc)
                    state_next = (pair_reg == 6'(a2bc_pkg::PAIR_LAST)) ? a2bc_pkg::S_LOAD
                                                                       : a2bc_pkg::S_EMIT_RD;
            default: state_next = a2bc_pkg::S_LOAD;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= a2bc_pkg::S_LOAD;
            xor_mode_reg  <= 1'b0;
            load_cnt_reg  <= '0;
            perm_reg      <= '0;
            mix_reg       <= '0;
            step_reg      <= '0;
            wr_cnt_reg    <= '0;
            pair_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                xor_mode_reg <= cfg_wdata;
            if (in_acc)
                load_cnt_reg <= load_cnt_reg + 1'b1;
            if (state_reg == a2bc_pkg::S_ADD)
                step_reg <= step_reg + 1'b1;
            if (state_reg == a2bc_pkg::S_WR)
            begin
                wr_cnt_reg <= wr_cnt_reg + 1'b1;
                if (wr_cnt_reg == 2'd3)
                begin
                    mix_reg <= mix_reg + 1'b1;
                    if (last_mix)
                        perm_reg <= perm_reg + 1'b1;
                end
            end
            // result register valid in the cycle after the emit read
            if (state_reg == a2bc_pkg::S_EMIT_RD)
                out_valid_reg <= 1'b1;
            else if (out_acc)
            begin
                out_valid_reg <= 1'b0;
                pair_reg <= pair_reg + 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == a2bc_pkg::S_RDC)
        begin
            a_reg <= z_rd0;
            b_reg <= z_rd1;
        end
        if (state_reg == a2bc_pkg::S_LATC)
        begin
            c_reg <= z_rd0;
            d_reg <= z_rd1;
        end
        if (state_reg == a2bc_pkg::S_MUL)
            prod_reg <= op_x[HW-1:0] * op_y[HW-1:0];
        if (state_reg == a2bc_pkg::S_ADD)
        begin
            if (step_reg[0])
            begin
                c_reg <= sum;
                b_reg <= mixed;
            end
            else
            begin
                a_reg <= sum;
                d_reg <= mixed;
            end
        end
        if (state_reg == a2bc_pkg::S_EMIT_RD)
            out_last_reg <= (pair_reg == 6'(a2bc_pkg::PAIR_LAST));
    end

    // Result pair: R ^ Z, optionally ^ old block, from the registered reads
    always_comb
    begin
        out_even = work_rd0 ^ z_rd0 ^ (xor_mode_reg ? feed_rd0 : '0);
        out_odd  = work_rd1 ^ z_rd1 ^ (xor_mode_reg ? feed_rd1 : '0);
    end

`ifndef SYNTHESIS
    // input side is never open while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !out_valid_reg)
        else $error("input ready while a result is pending");

    // every add step follows its multiply step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == a2bc_pkg::S_ADD) |-> ($past(state_reg) == a2bc_pkg::S_MUL))
        else $error("add step without multiply");

    // tlast only on the final pair
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (pair_reg == 6'(a2bc_pkg::PAIR_LAST)))
        else $error("tlast on wrong pair");

    // a result is valid only while waiting in the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (state_reg == a2bc_pkg::S_EMIT_OUT))
        else $error("result valid outside output state");
`endif

endmodule
